### rtl/psa_pkg.sv
`default_nettype none
package psa_pkg;

   localparam int FRAME_WIDTH  = 320;
   localparam int FRAME_HEIGHT = 240;
   localparam int PIXEL_COUNT  = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int ADDR_W       = $clog2(PIXEL_COUNT);

   localparam int CH_W      = 20;
   localparam int COLOR_W   = 16;
   localparam int WEIGHT_W  = 17;
   localparam int GAIN_W    = 16;
   localparam int POS_W     = 19;
   localparam int COORD_W   = 12;
   localparam int CONTRIB_W = 18;
   localparam int SCALE_W   = COLOR_W + WEIGHT_W;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 3;
   localparam int TAP_W     = 3;

   localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

   localparam logic [TAP_W-1:0] TAP_CENTER = 3'd0;
   localparam logic [TAP_W-1:0] TAP_LAST   = 3'd4;

   localparam logic [CH_W-1:0]   BG_RED_RESET      = 20'd983;
   localparam logic [CH_W-1:0]   BG_GREEN_RESET    = 20'd0;
   localparam logic [CH_W-1:0]   BG_BLUE_RESET     = 20'd3277;
   localparam logic [GAIN_W-1:0] CENTER_GAIN_RESET = 16'd55706;
   localparam logic [GAIN_W-1:0] ARM_GAIN_RESET    = 16'd19661;

   typedef enum logic [1:0] {
      CMD_SPLAT = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FILL  = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_BG_RED      = 3'd0,
      REG_BG_GREEN    = 3'd1,
      REG_BG_BLUE     = 3'd2,
      REG_CENTER_GAIN = 3'd3,
      REG_ARM_GAIN    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } rgb_color_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_accum_type;

   typedef struct packed {
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
   } rgb_byte_type;

   typedef struct packed {
      logic              load_scale;
      logic              load_tap;
      logic [GAIN_W-1:0] gain;
   } mac_ctrl_type;

   function automatic logic [COORD_W:0] tap_dx(input logic [TAP_W-1:0] tap);
      logic [COORD_W:0] d;
      case (tap)
         3'd1:    d = 13'h0001;
         3'd2:    d = 13'h1FFF;
         default: d = 13'h0000;
      endcase
      return d;
   endfunction

   function automatic logic [COORD_W:0] tap_dy(input logic [TAP_W-1:0] tap);
      logic [COORD_W:0] d;
      case (tap)
         3'd3:    d = 13'h0001;
         3'd4:    d = 13'h1FFF;
         default: d = 13'h0000;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

### rtl/psa_channels.sv
`default_nettype none
interface psa_req_bus;
   logic                                valid;
   logic                                ready;
   psa_pkg::cmd_type                    cmd;
   logic signed [psa_pkg::POS_W-1:0]    pos_x;
   logic signed [psa_pkg::POS_W-1:0]    pos_y;
   logic [psa_pkg::COLOR_W-1:0]         red;
   logic [psa_pkg::COLOR_W-1:0]         green;
   logic [psa_pkg::COLOR_W-1:0]         blue;
   logic [psa_pkg::WEIGHT_W-1:0]        weight;
   logic [8:0]                          pixel_x;
   logic [7:0]                          pixel_y;

   modport source (output valid, cmd, pos_x, pos_y, red, green, blue, weight,
                   pixel_x, pixel_y, input ready);
   modport sink (input valid, cmd, pos_x, pos_y, red, green, blue, weight,
                 pixel_x, pixel_y, output ready);
endinterface

interface psa_rsp_bus;
   logic                       valid;
   logic                       ready;
   logic [psa_pkg::BYTE_W-1:0] out_red;
   logic [psa_pkg::BYTE_W-1:0] out_green;
   logic [psa_pkg::BYTE_W-1:0] out_blue;

   modport source (output valid, out_red, out_green, out_blue, input ready);
   modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface psa_csr_bus;
   logic                          valid;
   logic                          ready;
   logic [psa_pkg::CSR_IDX_W-1:0] index;
   logic [psa_pkg::CH_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/point_splat_accumulator_unit.sv
// Additive point splat accumulator over a 320 x 240 RGB buffer, Q4.16 per channel.
// Items arrive on req_bus: splat (cmd 0) adds a weighted color to five pixels in a
// plus shape around the rounded point, read (cmd 1) returns one pixel as three
// 8-bit levels on rsp_bus, and fill (cmd 2) writes the background color.
// Background levels and tap gains are written on csr_bus, which is always ready.
// The block takes one item at a time and holds req_bus.ready low while it works.
// A splat is first accepted and scaled; then each tap inside the frame takes one read
// and one write of the single accumulator memory through one shared three-lane
// multiplier, and each tap outside it is skipped. A read reads the memory and then
// loads the output register; a fill is a single write; an unused command is dropped.
// A result waits in the output register until rsp_bus.ready is high; a later
// read then holds in its last step until the register is free.
// Reset returns the control state and registers to their defaults; the buffer
// itself is not cleared, so every pixel must be filled before it is splatted.
`default_nettype none
module point_splat_accumulator_unit (
   input wire logic  clock,
   input wire logic  reset,
   psa_req_bus.sink   req_bus,
   psa_rsp_bus.source rsp_bus,
   psa_csr_bus.sink   csr_bus
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SCALE     = 7'b0000010,
      ST_TAP_READ  = 7'b0000100,
      ST_TAP_WRITE = 7'b0001000,
      ST_PIX_READ  = 7'b0010000,
      ST_PIX_DATA  = 7'b0100000,
      ST_FILL      = 7'b1000000
   } state_type;

   localparam int AW = psa_pkg::ADDR_W;
   localparam int CW = psa_pkg::COORD_W;

   state_type state_ff, state_in;
   logic [psa_pkg::TAP_W-1:0] tap_ff, tap_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [psa_pkg::CH_W-1:0]   bg_red_ff, bg_green_ff, bg_blue_ff;
   logic [psa_pkg::GAIN_W-1:0] center_gain_ff, arm_gain_ff;

   logic [CW-1:0]                 cx_ff, cy_ff;
   psa_pkg::rgb_color_type        color_ff;
   logic [psa_pkg::WEIGHT_W-1:0]  weight_ff;
   logic [AW-1:0]                 pix_addr_ff;
   logic                          pix_inside_ff;
   psa_pkg::rgb_byte_type         rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic [psa_pkg::POS_W:0] pos_x_biased, pos_y_biased;
   logic                  req_inside;
   logic [AW-1:0]         req_addr;
   logic [CW:0]           tap_x, tap_y;
   logic                  tap_inside;
   logic [AW-1:0]         tap_addr;
   logic                  rsp_load;

   psa_pkg::mac_ctrl_type mac_ctrl;
   psa_pkg::rgb_accum_type mac_sum, ram_acc;
   logic [3*psa_pkg::CH_W-1:0] ram_rdata;
   logic ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [3*psa_pkg::CH_W-1:0] ram_wdata;

   function automatic logic [psa_pkg::BYTE_W-1:0] to_byte(
      input logic [psa_pkg::CH_W-1:0] ch);
      logic [psa_pkg::CH_W+7:0] v;
      v = ((psa_pkg::CH_W + 8)'(ch) << 8) - (psa_pkg::CH_W + 8)'(ch);
      return (v[psa_pkg::CH_W+7:16] > 12'd255) ? 8'hFF : v[23:16];
   endfunction

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign pos_x_biased = {req_bus.pos_x[psa_pkg::POS_W-1], req_bus.pos_x} + 20'd128;
   assign pos_y_biased = {req_bus.pos_y[psa_pkg::POS_W-1], req_bus.pos_y} + 20'd128;

   assign req_inside = (11'(req_bus.pixel_x) < 11'(psa_pkg::FRAME_WIDTH)) &&
                       (11'(req_bus.pixel_y) < 11'(psa_pkg::FRAME_HEIGHT));
   assign req_addr = AW'(req_bus.pixel_y) * AW'(psa_pkg::FRAME_WIDTH) + AW'(req_bus.pixel_x);

   assign tap_x = {cx_ff[CW-1], cx_ff} + psa_pkg::tap_dx(tap_ff);
   assign tap_y = {cy_ff[CW-1], cy_ff} + psa_pkg::tap_dy(tap_ff);
   assign tap_inside = !tap_x[CW] && (tap_x[CW-1:0] < CW'(psa_pkg::FRAME_WIDTH)) &&
                       !tap_y[CW] && (tap_y[CW-1:0] < CW'(psa_pkg::FRAME_HEIGHT));
   assign tap_addr = AW'(tap_y[CW-1:0]) * AW'(psa_pkg::FRAME_WIDTH) + AW'(tap_x[CW-1:0]);

   assign ram_acc = ram_rdata;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      rsp_load     = 1'b0;
      mac_ctrl.load_scale = 1'b0;
      mac_ctrl.load_tap   = 1'b0;
      mac_ctrl.gain = (tap_ff == psa_pkg::TAP_CENTER) ? center_gain_ff : arm_gain_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_wr_addr  = tap_addr;
      ram_rd_addr  = tap_addr;
      ram_wdata    = mac_sum;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_bus.cmd)
                  psa_pkg::CMD_SPLAT: state_in = ST_SCALE;
                  psa_pkg::CMD_READ:  state_in = ST_PIX_READ;
                  psa_pkg::CMD_FILL:  state_in = ST_FILL;
                  default:            state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCALE: begin
            mac_ctrl.load_scale = 1'b1;
            tap_in   = psa_pkg::TAP_CENTER;
            state_in = ST_TAP_READ;
         end
         ST_TAP_READ: begin
            if (tap_inside) begin
               ram_rd_en = 1'b1;
               mac_ctrl.load_tap = 1'b1;
               state_in = ST_TAP_WRITE;
            end else if (tap_ff == psa_pkg::TAP_LAST) begin
               state_in = ST_IDLE;
            end else begin
               tap_in = tap_ff + 3'd1;
            end
         end
         ST_TAP_WRITE: begin
            ram_wr_en = 1'b1;
            if (tap_ff == psa_pkg::TAP_LAST) begin
               state_in = ST_IDLE;
            end else begin
               tap_in   = tap_ff + 3'd1;
               state_in = ST_TAP_READ;
            end
         end
         ST_PIX_READ: begin
            ram_rd_en   = pix_inside_ff;
            ram_rd_addr = pix_addr_ff;
            state_in    = ST_PIX_DATA;
         end
         ST_PIX_DATA: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            ram_wr_en   = pix_inside_ff;
            ram_wr_addr = pix_addr_ff;
            ram_wdata   = {bg_red_ff, bg_green_ff, bg_blue_ff};
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (pix_inside_ff) begin
         rsp_data_in.red   = to_byte(ram_acc.red);
         rsp_data_in.green = to_byte(ram_acc.green);
         rsp_data_in.blue  = to_byte(ram_acc.blue);
      end else begin
         rsp_data_in = '0;
      end
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         tap_ff         <= psa_pkg::TAP_CENTER;
         rsp_valid_ff   <= 1'b0;
         bg_red_ff      <= psa_pkg::BG_RED_RESET;
         bg_green_ff    <= psa_pkg::BG_GREEN_RESET;
         bg_blue_ff     <= psa_pkg::BG_BLUE_RESET;
         center_gain_ff <= psa_pkg::CENTER_GAIN_RESET;
         arm_gain_ff    <= psa_pkg::ARM_GAIN_RESET;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               psa_pkg::REG_BG_RED:      bg_red_ff      <= csr_bus.data;
               psa_pkg::REG_BG_GREEN:    bg_green_ff    <= csr_bus.data;
               psa_pkg::REG_BG_BLUE:     bg_blue_ff     <= csr_bus.data;
               psa_pkg::REG_CENTER_GAIN: center_gain_ff <= csr_bus.data[psa_pkg::GAIN_W-1:0];
               psa_pkg::REG_ARM_GAIN:    arm_gain_ff    <= csr_bus.data[psa_pkg::GAIN_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff          <= pos_x_biased[psa_pkg::POS_W:8];
         cy_ff          <= pos_y_biased[psa_pkg::POS_W:8];
         color_ff.red   <= req_bus.red;
         color_ff.green <= req_bus.green;
         color_ff.blue  <= req_bus.blue;
         weight_ff      <= req_bus.weight;
         pix_addr_ff    <= req_addr;
         pix_inside_ff  <= req_inside;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_data_ff.red;
   assign rsp_bus.out_green = rsp_data_ff.green;
   assign rsp_bus.out_blue  = rsp_data_ff.blue;

   psa_mac_unit u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .color  (color_ff),
      .weight (weight_ff),
      .acc    (ram_acc),
      .sum    (mac_sum)
   );

   psa_ram #(
      .WIDTH (3 * psa_pkg::CH_W),
      .DEPTH (psa_pkg::PIXEL_COUNT)
   ) u_accum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rdata)
   );

endmodule
`default_nettype wire

### rtl/psa_ram.sv
`default_nettype none
module psa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/psa_mac_unit.sv
`default_nettype none
module psa_mac_unit (
   input  wire logic                   clock,
   input  wire psa_pkg::mac_ctrl_type  ctrl,
   input  wire psa_pkg::rgb_color_type color,
   input  wire logic [psa_pkg::WEIGHT_W-1:0] weight,
   input  wire psa_pkg::rgb_accum_type acc,
   output psa_pkg::rgb_accum_type      sum
);

   localparam int PROD_W = psa_pkg::SCALE_W + psa_pkg::WEIGHT_W;

   logic [psa_pkg::COLOR_W-1:0] col [3];
   logic [psa_pkg::CH_W-1:0]    acc_lane [3];
   logic [psa_pkg::CH_W-1:0]    sum_lane [3];

   assign col[0] = color.red;
   assign col[1] = color.green;
   assign col[2] = color.blue;
   assign acc_lane[0] = acc.red;
   assign acc_lane[1] = acc.green;
   assign acc_lane[2] = acc.blue;
   assign sum.red   = sum_lane[0];
   assign sum.green = sum_lane[1];
   assign sum.blue  = sum_lane[2];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic [psa_pkg::SCALE_W-1:0]   scale_ff;
      logic [psa_pkg::CONTRIB_W-1:0] contrib_ff;
      logic [psa_pkg::SCALE_W-1:0]   op_a;
      logic [psa_pkg::WEIGHT_W-1:0]  op_b;
      logic [PROD_W-1:0]             prod;
      logic [PROD_W-1:0]             rounded;
      logic [psa_pkg::CH_W:0]        total;

      always_comb begin
         if (ctrl.load_scale) begin
            op_a = psa_pkg::SCALE_W'(col[i]);
            op_b = weight;
         end else begin
            op_a = scale_ff;
            op_b = psa_pkg::WEIGHT_W'(ctrl.gain);
         end
         prod    = PROD_W'(op_a) * PROD_W'(op_b);
         rounded = prod + (PROD_W'(1) << 30);
         total   = (psa_pkg::CH_W + 1)'(acc_lane[i]) + (psa_pkg::CH_W + 1)'(contrib_ff);
         sum_lane[i] = total[psa_pkg::CH_W] ? psa_pkg::CH_MAX
                                            : total[psa_pkg::CH_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (ctrl.load_scale) begin
            scale_ff <= prod[psa_pkg::SCALE_W-1:0];
         end
         if (ctrl.load_tap) begin
            contrib_ff <= rounded[48:31];
         end
      end
   end

endmodule
`default_nettype wire
